### hw/rtl/iem_pkg.sv
package iem_pkg;

  typedef enum logic [3:0] {
    PH_IDLE, PH_START_A, PH_START_B, PH_TX_SET, PH_TX_HIGH, PH_TX_LOW,
    PH_ACK_REL, PH_ACK_HIGH, PH_ACK_POLL, PH_RX_LOW, PH_RX_HIGH,
    PH_NACK_LOW, PH_NACK_HIGH, PH_STOP_LOW, PH_STOP_HIGH, PH_SETTLE
  } phase_e;

  typedef enum logic [3:0] {
    OP_END, OP_START, OP_TXW, OP_TXR, OP_TXD, OP_ACK, OP_RX, OP_STOP,
    OP_SETTLE, OP_MOD
  } op_e;

  // how the back end loads its delay counter
  typedef enum logic [2:0] {
    DLY_HOLD, DLY_DEC, DLY_ZERO, DLY_1US, DLY_2US, DLY_4US, DLY_SETTLE
  } dly_e;

  typedef enum logic [1:0] {
    KIND_NOP, KIND_TICK, KIND_JOB
  } kind_e;

  localparam logic [2:0] REQ_TICK      = 3'd0;
  localparam logic [2:0] JOB_PROBE     = 3'd1;
  localparam logic [2:0] JOB_WRITE     = 3'd2;
  localparam logic [2:0] JOB_READ      = 3'd3;
  localparam logic [2:0] JOB_WRITE_BIT = 3'd4;
  localparam logic [2:0] JOB_READ_BIT  = 3'd5;
  localparam logic [2:0] JOB_ABORT     = 3'd6;

  localparam logic [1:0] CFG_TPU    = 2'd0;
  localparam logic [1:0] CFG_LIMIT  = 2'd1;
  localparam logic [1:0] CFG_ADDR   = 2'd2;
  localparam logic [1:0] CFG_SETTLE = 2'd3;
  localparam int unsigned CFG_DW    = 20;

  localparam logic [7:0] PROBE_BYTE = 8'hFF;

  typedef struct packed {
    kind_e      kind;
    logic [2:0] req_type;
    logic [7:0] write_value;
    logic [2:0] bit_index;
    logic       bit_value;
    logic       sda_in;
  } item_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_driving;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_byte;
    logic       read_bit;
    logic       ack_failed;
    logic       rejected;
  } res_t;

  typedef struct packed {
    phase_e     phase;
    dly_e       dsel;
    logic [3:0] bit_count;
    logic [7:0] shift_reg;
    logic [2:0] job;
    logic [2:0] saved_index;
    logic       saved_value;
    logic [7:0] ack_count;
    logic [7:0] last_read;
    logic       scl;
    logic       sda;
    logic       drv;
    logic [3:0] stage;
    logic [7:0] data_byte;
    logic       read_bit;
    logic       ack_fail;
    logic       done;
  } st_t;

  typedef struct packed {
    st_t  st;
    logic rej;
  } step_t;

  // engine state after reset: idle, both lines high and driven
  function automatic st_t st_reset();
    st_t r;
    r     = '0;
    r.scl = 1'b1;
    r.sda = 1'b1;
    r.drv = 1'b1;
    return r;
  endfunction

  function automatic op_e script(logic [2:0] job, logic [3:0] stage);
    op_e op;
    op = OP_END;
    unique case (job)
      JOB_PROBE: begin
        unique case (stage)
          4'd0: op = OP_START;  4'd1: op = OP_TXW;  4'd2: op = OP_ACK;
          4'd3: op = OP_STOP;   4'd4: op = OP_START; 4'd5: op = OP_TXW;
          4'd6: op = OP_ACK;    4'd7: op = OP_TXD;  4'd8: op = OP_ACK;
          4'd9: op = OP_STOP;   4'd10: op = OP_SETTLE;
          default: op = OP_END;
        endcase
      end
      JOB_WRITE: begin
        unique case (stage)
          4'd0: op = OP_START; 4'd1: op = OP_TXW; 4'd2: op = OP_ACK;
          4'd3: op = OP_TXD;   4'd4: op = OP_ACK; 4'd5: op = OP_STOP;
          4'd6: op = OP_SETTLE;
          default: op = OP_END;
        endcase
      end
      JOB_READ, JOB_READ_BIT: begin
        unique case (stage)
          4'd0: op = OP_START; 4'd1: op = OP_TXR; 4'd2: op = OP_ACK;
          4'd3: op = OP_RX;    4'd4: op = OP_STOP;
          default: op = OP_END;
        endcase
      end
      JOB_WRITE_BIT: begin
        unique case (stage)
          4'd0: op = OP_START; 4'd1: op = OP_TXR;  4'd2: op = OP_ACK;
          4'd3: op = OP_RX;    4'd4: op = OP_STOP; 4'd5: op = OP_MOD;
          4'd6: op = OP_START; 4'd7: op = OP_TXW;  4'd8: op = OP_ACK;
          4'd9: op = OP_TXD;   4'd10: op = OP_ACK; 4'd11: op = OP_STOP;
          4'd12: op = OP_SETTLE;
          default: op = OP_END;
        endcase
      end
      JOB_ABORT: op = (stage == 4'd0) ? OP_STOP : OP_END;
      default: op = OP_END;
    endcase
    return op;
  endfunction

  function automatic st_t tx_setup(st_t s);
    st_t r;
    r = s;
    r.scl   = 1'b0;
    r.sda   = s.shift_reg[7];
    r.drv   = 1'b1;
    r.phase = PH_TX_SET;
    r.dsel  = DLY_2US;
    return r;
  endfunction

  function automatic st_t begin_op(st_t s, op_e op, logic [6:0] addr);
    st_t r;
    logic [7:0] m;
    r = s;
    m = 8'd1 << s.saved_index;
    unique case (op)
      OP_START: begin
        r.scl = 1'b1; r.sda = 1'b1; r.drv = 1'b1;
        r.phase = PH_START_A; r.dsel = DLY_4US;
      end
      OP_TXW: begin
        r.shift_reg = {addr, 1'b0}; r.bit_count = '0; r = tx_setup(r);
      end
      OP_TXR: begin
        r.shift_reg = {addr, 1'b1}; r.bit_count = '0; r = tx_setup(r);
      end
      OP_TXD: begin
        r.shift_reg = s.data_byte; r.bit_count = '0; r = tx_setup(r);
      end
      OP_ACK: begin
        r.sda = 1'b1; r.drv = 1'b0; r.phase = PH_ACK_REL; r.dsel = DLY_1US;
      end
      OP_RX: begin
        r.drv = 1'b0; r.scl = 1'b0; r.bit_count = '0; r.shift_reg = '0;
        r.phase = PH_RX_LOW; r.dsel = DLY_2US;
      end
      OP_STOP: begin
        r.scl = 1'b0; r.sda = 1'b0; r.drv = 1'b1;
        r.phase = PH_STOP_LOW; r.dsel = DLY_4US;
      end
      OP_SETTLE: begin
        r.phase = PH_SETTLE; r.dsel = DLY_SETTLE;
      end
      OP_MOD: begin
        r.data_byte = s.saved_value ? (s.last_read | m) : (s.last_read & ~m);
      end
      default: begin
        if (s.job == JOB_READ_BIT) r.read_bit = s.last_read[s.saved_index];
        r.phase = PH_IDLE; r.dsel = DLY_ZERO; r.done = 1'b1;
      end
    endcase
    return r;
  endfunction

  // the modify op takes no time, so it chains straight into the next op
  function automatic st_t run_stage(st_t s, logic [6:0] addr);
    st_t r;
    op_e op;
    r  = s;
    op = script(r.job, r.stage);
    if (op == OP_MOD) begin
      r = begin_op(r, OP_MOD, addr);
      r.stage = r.stage + 4'd1;
      op = script(r.job, r.stage);
    end
    r = begin_op(r, op, addr);
    return r;
  endfunction

  function automatic st_t next_op(st_t s, logic [6:0] addr);
    st_t r;
    r = s;
    r.stage = s.stage + 4'd1;
    return run_stage(r, addr);
  endfunction

  function automatic st_t tick(st_t s, logic sda_in, logic gt1,
                               logic [7:0] limit, logic [6:0] addr);
    st_t r;
    r = s;
    if (s.phase == PH_IDLE) return r;
    if (s.phase != PH_ACK_POLL && gt1) begin
      r.dsel = DLY_DEC;
      return r;
    end
    unique case (s.phase)
      PH_START_A: begin r.sda = 1'b0; r.phase = PH_START_B; r.dsel = DLY_4US; end
      PH_START_B: begin r.scl = 1'b0; r = next_op(r, addr); end
      PH_TX_SET:  begin r.scl = 1'b1; r.phase = PH_TX_HIGH; r.dsel = DLY_2US; end
      PH_TX_HIGH: begin r.scl = 1'b0; r.phase = PH_TX_LOW; r.dsel = DLY_2US; end
      PH_TX_LOW: begin
        r.bit_count = s.bit_count + 4'd1;
        r.shift_reg = {s.shift_reg[6:0], 1'b0};
        if (r.bit_count < 4'd8) r = tx_setup(r);
        else r = next_op(r, addr);
      end
      PH_ACK_REL:  begin r.scl = 1'b1; r.phase = PH_ACK_HIGH; r.dsel = DLY_1US; end
      PH_ACK_HIGH: begin r.ack_count = '0; r.phase = PH_ACK_POLL; r.dsel = DLY_ZERO; end
      PH_ACK_POLL: begin
        if (!sda_in) begin
          r.scl = 1'b0; r = next_op(r, addr);
        end else if (s.ack_count >= limit) begin
          r.ack_fail = 1'b1; r.job = JOB_ABORT; r.stage = '0;
          r = run_stage(r, addr);
        end else begin
          r.ack_count = s.ack_count + 8'd1;
        end
      end
      PH_RX_LOW: begin r.scl = 1'b1; r.phase = PH_RX_HIGH; r.dsel = DLY_1US; end
      PH_RX_HIGH: begin
        r.shift_reg = {s.shift_reg[6:0], sda_in};
        r.bit_count = s.bit_count + 4'd1;
        if (r.bit_count < 4'd8) begin
          r.scl = 1'b0; r.phase = PH_RX_LOW; r.dsel = DLY_2US;
        end else begin
          r.last_read = r.shift_reg;
          r.scl = 1'b0; r.sda = 1'b1; r.drv = 1'b1;
          r.phase = PH_NACK_LOW; r.dsel = DLY_2US;
        end
      end
      PH_NACK_LOW:  begin r.scl = 1'b1; r.phase = PH_NACK_HIGH; r.dsel = DLY_2US; end
      PH_NACK_HIGH: begin r.scl = 1'b0; r = next_op(r, addr); end
      PH_STOP_LOW:  begin r.scl = 1'b1; r.phase = PH_STOP_HIGH; r.dsel = DLY_4US; end
      PH_STOP_HIGH: begin r.sda = 1'b1; r = next_op(r, addr); end
      PH_SETTLE:    r = next_op(r, addr);
      PH_IDLE:      begin r.phase = PH_IDLE; r.dsel = DLY_ZERO; end
    endcase
    return r;
  endfunction

  function automatic step_t step(st_t s, item_t it, logic gt1,
                                 logic [7:0] limit, logic [6:0] addr);
    step_t o;
    st_t r;
    r = s;
    r.done = 1'b0;
    r.dsel = DLY_HOLD;
    o.rej = 1'b0;
    unique case (it.kind)
      KIND_TICK: r = tick(r, it.sda_in, gt1, limit, addr);
      KIND_JOB: begin
        if (s.phase != PH_IDLE) begin
          o.rej = 1'b1;
        end else begin
          r.job         = it.req_type;
          r.saved_index = it.bit_index;
          r.saved_value = it.bit_value;
          r.data_byte   = (it.req_type == JOB_PROBE) ? PROBE_BYTE : it.write_value;
          r.ack_fail    = 1'b0;
          r.stage       = '0;
          r = run_stage(r, addr);
        end
      end
      default: ;
    endcase
    o.st = r;
    return o;
  endfunction

endpackage

### hw/rtl/i2c_expander_bit_master_core.sv
// an item's result is computed combinationally when the item is taken and is registered in the result queue
// throughput: one item per cycle while the result queue is not full, set by the combinational step of the bus engine
// a 2-entry queue on each side lets input and result sides stall on their own
// reset (async, active low): bus idle, scl and sda high and driven, queues empty
// config resets to 100 ticks/us, poll limit 250, address 32, settle 10000 us
module i2c_expander_bit_master_core import iem_pkg::*; #(
  parameter int unsigned DELAY_BITS = 24
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [CFG_DW-1:0] cfg_data_i,
  input  logic              push,
  output logic              full,
  input  logic [2:0]        req_type_i,
  input  logic [7:0]        write_value_i,
  input  logic [2:0]        bit_index_i,
  input  logic              bit_value_i,
  input  logic              sda_in_i,
  output logic              empty,
  input  logic              pop,
  output logic              scl_level_o,
  output logic              sda_level_o,
  output logic              sda_driving_o,
  output logic              busy_res_o,
  output logic              done_res_o,
  output logic [7:0]        read_byte_o,
  output logic              read_bit_o,
  output logic              ack_failed_o,
  output logic              rejected_o
);

  item_t item;
  logic  item_valid, take, res_full, res_push;
  res_t  res_in, res_out;

  iem_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .full_o        (full),
    .req_type_i    (req_type_i),
    .write_value_i (write_value_i),
    .bit_index_i   (bit_index_i),
    .bit_value_i   (bit_value_i),
    .sda_in_i      (sda_in_i),
    .take_i        (take),
    .item_o        (item),
    .valid_o       (item_valid)
  );

  iem_back #(.DELAY_BITS(DELAY_BITS)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .valid_i    (item_valid),
    .item_i     (item),
    .take_o     (take),
    .res_full_i (res_full),
    .res_push_o (res_push),
    .res_o      (res_in)
  );

  iem_fifo #(.T(res_t)) u_res_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_out),
    .empty_o (empty)
  );

  assign scl_level_o   = res_out.scl_level;
  assign sda_level_o   = res_out.sda_level;
  assign sda_driving_o = res_out.sda_driving;
  assign busy_res_o    = res_out.busy_res;
  assign done_res_o    = res_out.done_res;
  assign read_byte_o   = res_out.read_byte;
  assign read_bit_o    = res_out.read_bit;
  assign ack_failed_o  = res_out.ack_failed;
  assign rejected_o    = res_out.rejected;

endmodule

### hw/rtl/iem_fifo.sv
module iem_fifo import iem_pkg::*; #(
  parameter type T = logic
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  T     data_i,
  output logic full_o,
  input  logic pop_i,
  output T     data_o,
  output logic empty_o
);

  T           mem [2];
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem[rd_q];

  always_comb begin
    wr_d  = do_push ? ~wr_q : wr_q;
    rd_d  = do_pop ? ~rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem[wr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

### hw/rtl/iem_front.sv
module iem_front import iem_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  output logic       full_o,
  input  logic [2:0] req_type_i,
  input  logic [7:0] write_value_i,
  input  logic [2:0] bit_index_i,
  input  logic       bit_value_i,
  input  logic       sda_in_i,
  input  logic       take_i,
  output item_t      item_o,
  output logic       valid_o
);

  item_t it;
  logic  empty;

  always_comb begin
    it.req_type    = req_type_i;
    it.write_value = write_value_i;
    it.bit_index   = bit_index_i;
    it.bit_value   = bit_value_i;
    it.sda_in      = sda_in_i;
    // request codes above JOB_READ_BIT, abort included, become no-ops
    if (req_type_i == REQ_TICK) it.kind = KIND_TICK;
    else if (req_type_i <= JOB_READ_BIT) it.kind = KIND_JOB;
    else it.kind = KIND_NOP;
  end

  iem_fifo #(.T(item_t)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i),
    .data_i  (it),
    .full_o  (full_o),
    .pop_i   (take_i),
    .data_o  (item_o),
    .empty_o (empty)
  );

  assign valid_o = !empty;

endmodule

### hw/rtl/iem_back.sv
module iem_back import iem_pkg::*; #(
  parameter int unsigned DELAY_BITS = 24
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [CFG_DW-1:0] cfg_data_i,
  input  logic              valid_i,
  input  item_t             item_i,
  output logic              take_o,
  input  logic              res_full_i,
  output logic              res_push_o,
  output res_t              res_o
);

  localparam int unsigned PW = 30;

  logic [9:0]            tpu_q;
  logic [7:0]            limit_q;
  logic [6:0]            addr_q;
  logic [19:0]           settle_us_q;
  logic [DELAY_BITS-1:0] settle_q, settle_d;
  logic [PW-1:0]         prod;
  logic [DELAY_BITS-1:0] delay_q, delay_d;
  st_t                   st_q;
  step_t                 nxt;
  logic                  fire;

  // settle ticks precomputed from config, one multiplier
  assign prod = settle_us_q * tpu_q;
  if (DELAY_BITS >= PW) begin : g_wide
    assign settle_d = DELAY_BITS'(prod);
  end else begin : g_sat
    assign settle_d = (|prod[PW-1:DELAY_BITS]) ? '1 : prod[DELAY_BITS-1:0];
  end

  assign fire   = valid_i && !res_full_i;
  assign take_o = fire;

  always_comb begin
    nxt = step(st_q, item_i, (delay_q > DELAY_BITS'(1)), limit_q, addr_q);
  end

  always_comb begin
    unique case (nxt.st.dsel)
      DLY_HOLD:   delay_d = delay_q;
      DLY_DEC:    delay_d = delay_q - DELAY_BITS'(1);
      DLY_ZERO:   delay_d = '0;
      DLY_1US:    delay_d = DELAY_BITS'({2'b00, tpu_q});
      DLY_2US:    delay_d = DELAY_BITS'({1'b0, tpu_q, 1'b0});
      DLY_4US:    delay_d = DELAY_BITS'({tpu_q, 2'b00});
      DLY_SETTLE: delay_d = settle_q;
      default:    delay_d = delay_q;
    endcase
  end

  always_comb begin
    res_o.scl_level   = nxt.st.scl;
    res_o.sda_level   = nxt.st.sda;
    res_o.sda_driving = nxt.st.drv;
    res_o.busy_res    = (nxt.st.phase != PH_IDLE);
    res_o.done_res    = nxt.st.done;
    res_o.read_byte   = nxt.st.last_read;
    res_o.read_bit    = nxt.st.read_bit;
    res_o.ack_failed  = nxt.st.ack_fail;
    res_o.rejected    = nxt.rej;
  end
  assign res_push_o = fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tpu_q       <= 10'd100;
      limit_q     <= 8'd250;
      addr_q      <= 7'd32;
      settle_us_q <= 20'd10000;
      settle_q    <= '0;
    end else begin
      settle_q <= settle_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_TPU:    tpu_q       <= cfg_data_i[9:0];
          CFG_LIMIT:  limit_q     <= cfg_data_i[7:0];
          CFG_ADDR:   addr_q      <= cfg_data_i[6:0];
          CFG_SETTLE: settle_us_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= st_reset();
      delay_q <= '0;
    end else if (fire) begin
      st_q    <= nxt.st;
      delay_q <= delay_d;
    end
  end

endmodule

### hw/rtl/iem_checker.sv
module iem_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       empty,
  input logic       pop,
  input logic       scl_level_o,
  input logic       sda_level_o,
  input logic       sda_driving_o,
  input logic       busy_res_o,
  input logic       done_res_o,
  input logic [7:0] read_byte_o,
  input logic       rejected_o
);

  // a waiting item holds until taken
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> ($stable(read_byte_o) && $stable(scl_level_o) &&
                          $stable(done_res_o)))
    else $error("result changed while waiting");

  // a finished job leaves the engine idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && done_res_o) |-> !busy_res_o)
    else $error("done while busy");

  // a request is only turned away while a job runs
  a_rej_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && rejected_o) |-> (busy_res_o && !done_res_o))
    else $error("rejected while idle");

  // a released data line is reported high
  a_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !sda_driving_o) |-> sda_level_o)
    else $error("released sda not high");

endmodule

bind i2c_expander_bit_master_core iem_checker u_iem_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .empty         (empty),
  .pop           (pop),
  .scl_level_o   (scl_level_o),
  .sda_level_o   (sda_level_o),
  .sda_driving_o (sda_driving_o),
  .busy_res_o    (busy_res_o),
  .done_res_o    (done_res_o),
  .read_byte_o   (read_byte_o),
  .rejected_o    (rejected_o)
);

### bench/i2c_expander_bit_master_core_chk.sv
module i2c_expander_bit_master_core_chk import iem_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [CFG_DW-1:0] cfg_data_i,
  input  logic              push_i,
  input  logic              full_i,
  input  logic [2:0]        req_type_i,
  input  logic [7:0]        write_value_i,
  input  logic [2:0]        bit_index_i,
  input  logic              bit_value_i,
  input  logic              sda_in_i,
  input  logic              empty_i,
  input  logic              pop_i,
  input  logic              scl_level_i,
  input  logic              sda_level_i,
  input  logic              sda_driving_i,
  input  logic              busy_res_i,
  input  logic              done_res_i,
  input  logic [7:0]        read_byte_i,
  input  logic              read_bit_i,
  input  logic              ack_failed_i,
  input  logic              rejected_i,
  output int                mismatches_o,
  output int                pending_o
);

  localparam int unsigned DBITS = 24;
  localparam logic [63:0] DLY_CAP = (64'd1 << DBITS) - 64'd1;

  // bus configuration copy
  logic [9:0]  tpu;
  logic [7:0]  poll_limit;
  logic [6:0]  dev_addr;
  logic [19:0] settle_us;

  // bus engine copy
  phase_e            ph;
  logic [DBITS-1:0]  dcnt;
  logic [3:0]        bcnt, stg;
  logic [7:0]        shreg, ackc, lastrd, dbyte;
  logic [2:0]        jb, sidx;
  logic              sval, scl, sda, drv, rdbit, afail, dn;

  res_t line_states_q[$];

  task automatic report_mismatch(string msg);
    $display("mismatch: %s", msg);
    mismatches_o++;
  endtask

  task automatic cmp_field(string name, logic [7:0] got, logic [7:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  function automatic logic [DBITS-1:0] us_to_ticks(logic [19:0] us);
    logic [63:0] p;
    p = 64'(us) * 64'(tpu);
    if (p > DLY_CAP) p = DLY_CAP;
    return p[DBITS-1:0];
  endfunction

  function automatic void enter_phase(phase_e p, logic [19:0] us);
    ph   = p;
    dcnt = us_to_ticks(us);
  endfunction

  function automatic void drive_lines(logic c, logic d, logic e);
    scl = c; sda = d; drv = e;
  endfunction

  function automatic void send_bit();
    drive_lines(1'b0, shreg[7], 1'b1);
    enter_phase(PH_TX_SET, 20'd2);
  endfunction

  function automatic op_e script_op(logic [2:0] j, logic [3:0] s);
    op_e op;
    op = OP_END;
    case (j)
      JOB_PROBE:
        case (s)
          4'd0, 4'd4: op = OP_START;
          4'd1, 4'd5: op = OP_TXW;
          4'd2, 4'd6, 4'd8: op = OP_ACK;
          4'd3, 4'd9: op = OP_STOP;
          4'd7: op = OP_TXD;
          4'd10: op = OP_SETTLE;
          default: op = OP_END;
        endcase
      JOB_WRITE:
        case (s)
          4'd0: op = OP_START;
          4'd1: op = OP_TXW;
          4'd2, 4'd4: op = OP_ACK;
          4'd3: op = OP_TXD;
          4'd5: op = OP_STOP;
          4'd6: op = OP_SETTLE;
          default: op = OP_END;
        endcase
      JOB_READ, JOB_READ_BIT:
        case (s)
          4'd0: op = OP_START;
          4'd1: op = OP_TXR;
          4'd2: op = OP_ACK;
          4'd3: op = OP_RX;
          4'd4: op = OP_STOP;
          default: op = OP_END;
        endcase
      JOB_WRITE_BIT:
        case (s)
          4'd0, 4'd6: op = OP_START;
          4'd1: op = OP_TXR;
          4'd2, 4'd8, 4'd10: op = OP_ACK;
          4'd3: op = OP_RX;
          4'd4, 4'd11: op = OP_STOP;
          4'd5: op = OP_MOD;
          4'd7: op = OP_TXW;
          4'd9: op = OP_TXD;
          4'd12: op = OP_SETTLE;
          default: op = OP_END;
        endcase
      JOB_ABORT: op = (s == 4'd0) ? OP_STOP : OP_END;
      default: op = OP_END;
    endcase
    return op;
  endfunction

  // returns 1 when the operation takes no bus time
  function automatic bit launch_op(op_e op);
    logic [7:0] m;
    m = 8'd1 << sidx;
    case (op)
      OP_START: begin drive_lines(1'b1, 1'b1, 1'b1); enter_phase(PH_START_A, 20'd4); end
      OP_TXW: begin shreg = {dev_addr, 1'b0}; bcnt = '0; send_bit(); end
      OP_TXR: begin shreg = {dev_addr, 1'b1}; bcnt = '0; send_bit(); end
      OP_TXD: begin shreg = dbyte; bcnt = '0; send_bit(); end
      OP_ACK: begin sda = 1'b1; drv = 1'b0; enter_phase(PH_ACK_REL, 20'd1); end
      OP_RX: begin
        drv = 1'b0; scl = 1'b0; bcnt = '0; shreg = '0;
        enter_phase(PH_RX_LOW, 20'd2);
      end
      OP_STOP: begin drive_lines(1'b0, 1'b0, 1'b1); enter_phase(PH_STOP_LOW, 20'd4); end
      OP_SETTLE: enter_phase(PH_SETTLE, settle_us);
      OP_MOD: begin
        dbyte = sval ? (lastrd | m) : (lastrd & ~m);
        return 1'b1;
      end
      default: begin
        if (jb == JOB_READ_BIT) rdbit = lastrd[sidx];
        ph = PH_IDLE; dcnt = '0; dn = 1'b1;
      end
    endcase
    return 1'b0;
  endfunction

  function automatic void run_ops();
    while (launch_op(script_op(jb, stg))) stg = stg + 4'd1;
  endfunction

  function automatic void advance_op();
    stg = stg + 4'd1;
    run_ops();
  endfunction

  function automatic void bus_tick(logic line);
    if (ph == PH_IDLE) return;
    if (ph != PH_ACK_POLL && dcnt > 1) begin
      dcnt = dcnt - 1'b1;
      return;
    end
    case (ph)
      PH_START_A: begin sda = 1'b0; enter_phase(PH_START_B, 20'd4); end
      PH_START_B: begin scl = 1'b0; advance_op(); end
      PH_TX_SET: begin scl = 1'b1; enter_phase(PH_TX_HIGH, 20'd2); end
      PH_TX_HIGH: begin scl = 1'b0; enter_phase(PH_TX_LOW, 20'd2); end
      PH_TX_LOW: begin
        bcnt  = bcnt + 4'd1;
        shreg = {shreg[6:0], 1'b0};
        if (bcnt < 4'd8) send_bit();
        else advance_op();
      end
      PH_ACK_REL: begin scl = 1'b1; enter_phase(PH_ACK_HIGH, 20'd1); end
      PH_ACK_HIGH: begin ackc = '0; ph = PH_ACK_POLL; dcnt = '0; end
      PH_ACK_POLL: begin
        if (!line) begin
          scl = 1'b0; advance_op();
        end else if (ackc >= poll_limit) begin
          // missing acknowledge: stop and drop the rest of the job
          afail = 1'b1; jb = JOB_ABORT; stg = '0; run_ops();
        end else begin
          ackc = ackc + 8'd1;
        end
      end
      PH_RX_LOW: begin scl = 1'b1; enter_phase(PH_RX_HIGH, 20'd1); end
      PH_RX_HIGH: begin
        shreg = {shreg[6:0], line};
        bcnt  = bcnt + 4'd1;
        if (bcnt < 4'd8) begin
          scl = 1'b0; enter_phase(PH_RX_LOW, 20'd2);
        end else begin
          lastrd = shreg;
          drive_lines(1'b0, 1'b1, 1'b1);
          enter_phase(PH_NACK_LOW, 20'd2);
        end
      end
      PH_NACK_LOW: begin scl = 1'b1; enter_phase(PH_NACK_HIGH, 20'd2); end
      PH_NACK_HIGH: begin scl = 1'b0; advance_op(); end
      PH_STOP_LOW: begin scl = 1'b1; enter_phase(PH_STOP_HIGH, 20'd4); end
      PH_STOP_HIGH: begin sda = 1'b1; advance_op(); end
      PH_SETTLE: advance_op();
      default: begin ph = PH_IDLE; dcnt = '0; end
    endcase
  endfunction

  function automatic res_t predict_lines(logic [2:0] req, logic [7:0] wv, logic [2:0] bi,
                                         logic bv, logic line);
    res_t r;
    logic rej;
    rej = 1'b0;
    dn  = 1'b0;
    if (req == REQ_TICK) begin
      bus_tick(line);
    end else if (req <= JOB_READ_BIT) begin
      if (ph != PH_IDLE) begin
        rej = 1'b1;
      end else begin
        jb = req; sidx = bi; sval = bv;
        dbyte = (req == JOB_PROBE) ? PROBE_BYTE : wv;
        afail = 1'b0; stg = '0;
        run_ops();
      end
    end
    r.scl_level   = scl;
    r.sda_level   = sda;
    r.sda_driving = drv;
    r.busy_res    = (ph != PH_IDLE);
    r.done_res    = dn;
    r.read_byte   = lastrd;
    r.read_bit    = rdbit;
    r.ack_failed  = afail;
    r.rejected    = rej;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    if (!rst_ni) begin
      tpu = 10'd100; poll_limit = 8'd250; dev_addr = 7'd32; settle_us = 20'd10000;
      ph = PH_IDLE; dcnt = '0; bcnt = '0; stg = '0; shreg = '0; ackc = '0;
      lastrd = '0; dbyte = '0; jb = '0; sidx = '0; sval = 1'b0;
      drive_lines(1'b1, 1'b1, 1'b1);
      rdbit = 1'b0; afail = 1'b0; dn = 1'b0;
      line_states_q.delete();
      mismatches_o = 0;
      pending_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_TPU:    tpu = cfg_data_i[9:0];
          CFG_LIMIT:  poll_limit = cfg_data_i[7:0];
          CFG_ADDR:   dev_addr = cfg_data_i[6:0];
          CFG_SETTLE: settle_us = cfg_data_i[19:0];
          default: ;
        endcase
      end
      if (pop_i && !empty_i) begin
        if (line_states_q.size() == 0) begin
          report_mismatch("result with no item waiting");
        end else begin
          want = line_states_q.pop_front();
          cmp_field("scl_level", scl_level_i, want.scl_level);
          cmp_field("sda_level", sda_level_i, want.sda_level);
          cmp_field("sda_driving", sda_driving_i, want.sda_driving);
          cmp_field("busy_res", busy_res_i, want.busy_res);
          cmp_field("done_res", done_res_i, want.done_res);
          cmp_field("read_byte", read_byte_i, want.read_byte);
          cmp_field("read_bit", read_bit_i, want.read_bit);
          cmp_field("ack_failed", ack_failed_i, want.ack_failed);
          cmp_field("rejected", rejected_i, want.rejected);
        end
      end
      if (push_i && !full_i)
        line_states_q.push_back(predict_lines(req_type_i, write_value_i, bit_index_i,
                                              bit_value_i, sda_in_i));
      pending_o = line_states_q.size();
    end
  end

endmodule

### bench/i2c_expander_bit_master_core_tb.sv
module i2c_expander_bit_master_core_tb import iem_pkg::*;;

  localparam int CYCLE_LIMIT = 200000;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we = 1'b0;
  logic [1:0]        cfg_idx = CFG_TPU;
  logic [CFG_DW-1:0] cfg_data = '0;
  logic              push = 1'b0;
  logic              full;
  logic [2:0]        req_type = REQ_TICK;
  logic [7:0]        write_value = '0;
  logic [2:0]        bit_index = '0;
  logic              bit_value = 1'b0;
  logic              sda_in = 1'b1;
  logic              empty;
  logic              pop = 1'b0;
  logic              scl_level, sda_level, sda_driving, busy_res, done_res;
  logic [7:0]        read_byte;
  logic              read_bit, ack_failed, rejected;
  int                mismatches, pending;
  int                cycles = 0;
  int                tx_idle_on = 1, rx_idle_on = 1;
  bit                hold_req = 1'b0;
  logic              last_busy = 1'b0;

  always #1 clk_i = ~clk_i;

  i2c_expander_bit_master_core u_dut (
    .clk_i, .rst_ni,
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .push, .full,
    .req_type_i(req_type), .write_value_i(write_value), .bit_index_i(bit_index),
    .bit_value_i(bit_value), .sda_in_i(sda_in),
    .empty, .pop,
    .scl_level_o(scl_level), .sda_level_o(sda_level), .sda_driving_o(sda_driving),
    .busy_res_o(busy_res), .done_res_o(done_res), .read_byte_o(read_byte),
    .read_bit_o(read_bit), .ack_failed_o(ack_failed), .rejected_o(rejected)
  );

  i2c_expander_bit_master_core_chk u_chk (
    .clk_i, .rst_ni,
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .push_i(push), .full_i(full),
    .req_type_i(req_type), .write_value_i(write_value), .bit_index_i(bit_index),
    .bit_value_i(bit_value), .sda_in_i(sda_in),
    .empty_i(empty), .pop_i(pop),
    .scl_level_i(scl_level), .sda_level_i(sda_level), .sda_driving_i(sda_driving),
    .busy_res_i(busy_res), .done_res_i(done_res), .read_byte_i(read_byte),
    .read_bit_i(read_bit), .ack_failed_i(ack_failed), .rejected_i(rejected),
    .mismatches_o(mismatches), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("i2c_expander_bit_master_core regression: fail");
      $finish;
    end
  end

  always @(posedge clk_i)
    if (pop && !empty) last_busy <= busy_res;

  // result side: random stalls, one long hold-off on request
  initial begin
    int gap;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        gap = 400;
      end else begin
        gap = rx_idle_on ? $urandom_range(0, 14) : 0;
      end
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
      @(negedge clk_i);
    end
  end

  // entered and left at a falling edge; push stays high for back-to-back items
  task automatic push_item(logic [2:0] rq, logic [7:0] wv, logic [2:0] bi, logic bv,
                           logic line);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_type <= rq; write_value <= wv; bit_index <= bi; bit_value <= bv; sda_in <= line;
    push <= 1'b1;
    do @(posedge clk_i); while (full);
    @(negedge clk_i);
  endtask

  task automatic push_tick(logic line);
    push_item(REQ_TICK, 8'($urandom), 3'($urandom), 1'($urandom), line);
  endtask

  task automatic push_job(logic [2:0] rq, logic [7:0] wv, logic [2:0] bi, logic bv);
    push_item(rq, wv, bi, bv, 1'($urandom));
  endtask

  // tick the bus until the running job has ended and all results are in
  task automatic finish_job(bit sda_high);
    int saved;
    saved = tx_idle_on;
    tx_idle_on = 0;
    forever begin
      repeat (16) push_tick(sda_high ? 1'b1 : 1'($urandom));
      push <= 1'b0;
      @(negedge clk_i);
      while (pending != 0) @(negedge clk_i);
      if (!last_busy) break;
    end
    repeat (4) @(negedge clk_i);
    tx_idle_on = saved;
  endtask

  task automatic write_reg(logic [1:0] idx, logic [CFG_DW-1:0] val);
    cfg_we <= 1'b1; cfg_idx <= idx; cfg_data <= val;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_bus(logic [9:0] t, logic [7:0] lim, logic [6:0] addr,
                         logic [19:0] st);
    write_reg(CFG_TPU, CFG_DW'(t));
    write_reg(CFG_LIMIT, CFG_DW'(lim));
    write_reg(CFG_ADDR, CFG_DW'(addr));
    write_reg(CFG_SETTLE, st);
  endtask

  task automatic random_traffic(int n, int hi_pct, bit reads_only, bit hold_once);
    int r;
    logic [2:0] rq;
    for (int k = 0; k < n; k++) begin
      if (hold_once && k == 40) hold_req = 1'b1;
      r = $urandom_range(0, 99);
      if (r < 8) begin
        if (reads_only) begin
          case ($urandom_range(0, 3))
            0: rq = JOB_READ;
            1: rq = JOB_READ_BIT;
            2: rq = JOB_ABORT;
            default: rq = 3'd7;
          endcase
        end else begin
          rq = 3'($urandom_range(1, 7));
        end
        push_job(rq, 8'($urandom), 3'($urandom), 1'($urandom));
      end else begin
        push_tick($urandom_range(0, 99) < hi_pct);
      end
    end
  endtask

  initial begin
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: probe, write, write-bit and read-bit jobs, rejection, unused codes, missing acknowledge
    set_bus(10'd1, 8'd4, 7'd127, 20'd0);
    push_job(JOB_PROBE, 8'h00, 3'd0, 1'b0);
    push_job(JOB_WRITE, 8'h5A, 3'd3, 1'b1);
    finish_job(1'b0);
    push_job(JOB_WRITE_BIT, 8'hFF, 3'd7, 1'b0);
    finish_job(1'b0);
    push_job(JOB_READ_BIT, 8'h00, 3'd0, 1'b1);
    push_job(JOB_ABORT, 8'hFF, 3'd1, 1'b1);
    push_job(3'd7, 8'hFF, 3'd2, 1'b0);
    finish_job(1'b0);
    set_bus(10'd1, 8'd0, 7'd0, 20'd1);
    push_job(JOB_WRITE_BIT, 8'h3C, 3'd2, 1'b1);
    finish_job(1'b1);

    // random phases over several bus settings
    for (int p = 0; p < 6; p++) begin
      tx_idle_on = (p % 3 != 2);
      rx_idle_on = (p % 3 != 2);
      case (p)
        0: set_bus(10'd1, 8'd255, 7'd127, 20'd0);
        1: set_bus(10'd2, 8'd0, 7'd0, 20'd3);
        2: set_bus(10'($urandom_range(1, 3)), 8'($urandom), 7'($urandom),
                   20'($urandom_range(0, 5)));
        3: set_bus(10'd1, 8'd5, 7'($urandom), 20'hFFFFF);
        4: set_bus(10'd1, 8'd3, 7'($urandom), 20'd2);
        default: set_bus(10'($urandom_range(1, 2)), 8'($urandom_range(0, 20)),
                         7'($urandom), 20'($urandom_range(0, 3)));
      endcase
      case (p)
        3: random_traffic(100, 50, 1'b1, 1'b0);
        4: random_traffic(120, 85, 1'b0, 1'b0);
        default: random_traffic(120, 45, 1'b0, p == 1);
      endcase
      finish_job(1'b0);
    end

    push <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
    if (mismatches == 0)
      $display("i2c_expander_bit_master_core regression: pass");
    else
      $display("i2c_expander_bit_master_core regression: fail");
    $finish;
  end

endmodule

### filelist.f
hw/rtl/iem_pkg.sv
hw/rtl/iem_fifo.sv
hw/rtl/iem_front.sv
hw/rtl/iem_back.sv
hw/rtl/i2c_expander_bit_master_core.sv
hw/rtl/iem_checker.sv
bench/i2c_expander_bit_master_core_chk.sv
bench/i2c_expander_bit_master_core_tb.sv
